// ===== sv/delta_list_sleep_timer_queue_defines.svh =====
// Assertion macros for the delta list timer queue
`ifndef DELTA_LIST_SLEEP_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_SLEEP_TIMER_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DLQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define DLQ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define DLQ_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define DLQ_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== sv/dlq_pkg.sv =====
// Package: constants, types and codes for the delta list timer queue
package dlq_pkg;
    localparam int QueueDepth = 16;
    localparam int TaskIdBits = 16;
    localparam logic [63:0] NsPerSec = 64'd1000000000;

    typedef enum logic [1:0] {
        EV_ACCEPT = 2'd0,
        EV_FULL   = 2'd1,
        EV_WAKE   = 2'd2
    } event_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_TICK   = 5'b01000,
        ST_SHIFT  = 5'b10000
    } state_t;

    // per-cycle control driven into every cell
    typedef struct packed {
        logic shift_up;     // cells after pos take neighbor below
        logic shift_down;   // every cell takes neighbor above
        logic write_new;    // cell at pos takes new entry
        logic adjust;       // cell at pos subtracts sub value
    } cell_ctl_t;
endpackage

// ===== sv/delta_list_sleep_timer_queue.sv =====
// Top level: delta list sleep timer queue built from a row of entry cells
//
//  channel   direction  handshake        payload
//  request   in         start / busy     req_type task_id sleep_seconds sleep_nanoseconds elapsed_ns
//  result    out        strobe           event_kind woken_task last_event
//
// Sleep: busy through the multiply, a walk past each earlier list entry, and the shift;
// the result strobes in the first cycle after busy falls. Full reject: not busy,
// result in the next cycle. Tick: wakes due entries from the head, each strobed in the
// following cycle, then reduces the new head when time is left over; no result on an
// empty queue.
// Reset clears the fill count and control; cell contents stay undefined until written.
// Results are strobed for one cycle; the receiver cannot stall.
`include "delta_list_sleep_timer_queue_defines.svh"
module delta_list_sleep_timer_queue #(
    parameter int QUEUE_DEPTH  = dlq_pkg::QueueDepth,
    parameter int TASK_ID_BITS = dlq_pkg::TaskIdBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [15:0] task_id,
    input  logic [31:0] sleep_seconds,
    input  logic [29:0] sleep_nanoseconds,
    input  logic [63:0] elapsed_ns,
    output logic        strobe,
    output logic [1:0]  event_kind,
    output logic [15:0] woken_task,
    output logic        last_event
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

    dlq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [63:0]   rem_reg, rem_next;
    logic [63:0]   prod_reg, prod_next;
    logic [29:0]   nsec_reg;
    logic [TASK_ID_BITS-1:0] task_reg;
    logic          strobe_reg, strobe_next;
    dlq_pkg::event_t kind_reg, kind_next;
    logic [TASK_ID_BITS-1:0] otask_reg, otask_next;
    logic          last_reg, last_next;
    dlq_pkg::cell_ctl_t ctl;
    logic [63:0]   sub_val;

    logic [TASK_ID_BITS-1:0] cell_task  [QUEUE_DEPTH];
    logic [63:0]             cell_delta [QUEUE_DEPTH];

    logic [PW-1:0] pidx;
    logic [63:0]   cur_delta;
    logic [64:0]   sum;
    logic          accept;
    logic          tick_last;
    logic [63:0]   rem_after;

    assign pidx      = pos_reg[PW-1:0];
    assign cur_delta = cell_delta[pidx];
    assign sum       = {1'b0, prod_reg} + {35'd0, nsec_reg};
    assign accept    = start && !busy;
    assign busy      = (state_reg != dlq_pkg::ST_IDLE);

    // Tick finality: a wake is last if no further entry would wake. Look ahead
    // at cell 1 so the strobe carries the right last flag.
    assign rem_after = rem_reg - cell_delta[0];
    assign tick_last = (count_reg == CW'(1)) || (rem_after == '0)
                       || (cell_delta[1] > rem_after);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        prod_next   = prod_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        otask_next  = otask_reg;
        last_next   = 1'b0;
        ctl         = '0;
        sub_val     = rem_reg;
        unique case (state_reg)
            dlq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next = '0;
                    if (req_type)
                    begin
                        rem_next = elapsed_ns;
                        if (count_reg != '0)
                            state_next = dlq_pkg::ST_TICK;
                    end
                    else if (count_reg == FullCount)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = dlq_pkg::EV_FULL;
                        otask_next  = TASK_ID_BITS'(task_id);
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        prod_next  = {32'd0, sleep_seconds} * dlq_pkg::NsPerSec;
                        state_next = dlq_pkg::ST_MUL;
                    end
                end
            end
            dlq_pkg::ST_MUL:
            begin
                rem_next   = sum[64] ? '1 : sum[63:0];
                state_next = dlq_pkg::ST_WALK;
            end
            dlq_pkg::ST_WALK:
            begin
                if (pos_reg < count_reg && rem_reg >= cur_delta)
                begin
                    rem_next = rem_reg - cur_delta;
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    // reduce follower first, then open a slot and write
                    if (pos_reg < count_reg)
                        ctl.adjust = 1'b1;
                    state_next = dlq_pkg::ST_SHIFT;
                end
            end
            dlq_pkg::ST_SHIFT:
            begin
                ctl.shift_up  = 1'b1;
                ctl.write_new = 1'b1;
                count_next    = count_reg + 1'b1;
                strobe_next   = 1'b1;
                kind_next     = dlq_pkg::EV_ACCEPT;
                otask_next    = task_reg;
                last_next     = 1'b1;
                state_next    = dlq_pkg::ST_IDLE;
            end
            dlq_pkg::ST_TICK:
            begin
                if (cell_delta[0] <= rem_reg)
                begin
                    ctl.shift_down = 1'b1;
                    rem_next    = rem_reg - cell_delta[0];
                    count_next  = count_reg - 1'b1;
                    strobe_next = 1'b1;
                    kind_next   = dlq_pkg::EV_WAKE;
                    otask_next  = cell_task[0];
                    last_next   = tick_last;
                    if (count_reg == CW'(1) || rem_reg == cell_delta[0])
                        state_next = dlq_pkg::ST_IDLE;
                end
                else
                begin
                    ctl.adjust = 1'b1;
                    state_next = dlq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlq_pkg::ST_IDLE;
            end
        endcase
    end

    logic [PW-1:0] new_pos;
    assign new_pos = pidx;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            logic [TASK_ID_BITS-1:0] bt, at;
            logic [63:0]             bd, ad;
            logic                    tick_pos;
            if (g == 0)
            begin : g_first
                assign bt = cell_task[0];
                assign bd = cell_delta[0];
            end
            else
            begin : g_mid
                assign bt = cell_task[g-1];
                assign bd = cell_delta[g-1];
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_last
                assign at = cell_task[g];
                assign ad = cell_delta[g];
            end
            else
            begin : g_body
                assign at = cell_task[g+1];
                assign ad = cell_delta[g+1];
            end
            assign tick_pos = (state_reg == dlq_pkg::ST_TICK) ? (g == 0)
                              : (PW'(g) == new_pos);
            dlq_cell #(.TASK_ID_BITS(TASK_ID_BITS)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .at_pos     (tick_pos),
                .after_pos  (PW'(g) > new_pos),
                .new_task   (task_reg),
                .new_delta  (rem_reg),
                .sub_val    (sub_val),
                .below_task (bt),
                .below_delta(bd),
                .above_task (at),
                .above_delta(ad),
                .task_q     (cell_task[g]),
                .delta_q    (cell_delta[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dlq_pkg::ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        prod_reg  <= prod_next;
        kind_reg  <= kind_next;
        otask_reg <= otask_next;
        if (accept)
        begin
            nsec_reg <= sleep_nanoseconds;
            task_reg <= TASK_ID_BITS'(task_id);
        end
    end

    assign strobe     = strobe_reg;
    assign event_kind = kind_reg;
    assign woken_task = 16'(otask_reg);
    assign last_event = last_reg;

    `DLQ_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= FullCount,
        "fill count above depth")
    `DLQ_ASSERT_NXT(a_full_reject, clk, rst_n,
        accept && !req_type && count_reg == FullCount,
        strobe && event_kind == dlq_pkg::EV_FULL && last_event, "full not reported")
    `DLQ_ASSERT_IMP(a_strobe_idle, clk, rst_n, strobe && last_event && !busy,
        $past(busy) || $past(accept), "stray final result")
endmodule

// ===== sv/dlq_cell.sv =====
// One list entry: task id and delta, shifts to its neighbors
module dlq_cell #(
    parameter int TASK_ID_BITS = dlq_pkg::TaskIdBits
) (
    input  logic                    clk,
    input  dlq_pkg::cell_ctl_t      ctl,
    input  logic                    at_pos,
    input  logic                    after_pos,
    input  logic [TASK_ID_BITS-1:0] new_task,
    input  logic [63:0]             new_delta,
    input  logic [63:0]             sub_val,
    input  logic [TASK_ID_BITS-1:0] below_task,
    input  logic [63:0]             below_delta,
    input  logic [TASK_ID_BITS-1:0] above_task,
    input  logic [63:0]             above_delta,
    output logic [TASK_ID_BITS-1:0] task_q,
    output logic [63:0]             delta_q
);
    logic [TASK_ID_BITS-1:0] task_reg, task_next;
    logic [63:0]             delta_reg, delta_next;

    always_comb
    begin
        task_next  = task_reg;
        delta_next = delta_reg;
        if (ctl.shift_down)
        begin
            task_next  = above_task;
            delta_next = above_delta;
        end
        else if (ctl.shift_up && after_pos)
        begin
            task_next  = below_task;
            delta_next = below_delta;
        end
        else if (ctl.write_new && at_pos)
        begin
            task_next  = new_task;
            delta_next = new_delta;
        end
        else if (ctl.adjust && at_pos)
        begin
            delta_next = delta_reg - sub_val;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg  <= task_next;
        delta_reg <= delta_next;
    end

    assign task_q  = task_reg;
    assign delta_q = delta_reg;
endmodule
